// ===== src/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Shared sizes and the control structures that pass between the sequencer
// and the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM = 16;
  localparam int DATA_W  = 32;
  localparam int COL_W   = $clog2(MAX_DIM);
  localparam int SIZE_W  = 5;
  localparam int B_DEPTH = MAX_DIM * MAX_DIM;
  localparam int B_AW    = $clog2(B_DEPTH);
  localparam int NN_W    = 2 * SIZE_W;
  localparam int ADDR_W  = 3;

  // Word index of the configuration registers.
  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam logic OP_LOAD_B   = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

  // One multiply issued by the sequencer, travelling with its operands.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_term;
    logic             row_end;
    logic [COL_W-1:0] col;
  } mac_tag_t;

  // A finished dot product.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [COL_W-1:0]  col;
    logic              row_end;
  } mac_res_t;

  // Size in use: zero acts as one, anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] n;
    if (raw == '0) begin
      n = SIZE_W'(1);
    end else if (raw > SIZE_W'(MAX_DIM)) begin
      n = SIZE_W'(MAX_DIM);
    end else begin
      n = raw;
    end
    return n;
  endfunction

endpackage

// ===== src/imm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/imm_mac.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate datapath
// Aligns the issue tag with the memory read data, registers the wrapped
// product and accumulates one dot product per column.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  imm_pkg::mac_tag_t        tag_i,
  input  logic [imm_pkg::DATA_W-1:0] a_i,
  input  logic [imm_pkg::DATA_W-1:0] b_i,
  output imm_pkg::mac_res_t        res_o
);
  import imm_pkg::*;

  mac_tag_t          rd_tag_q;
  mac_tag_t          prod_tag_q;
  logic [DATA_W-1:0] prod_d, prod_q;
  logic [DATA_W-1:0] acc_d, acc_q;

  // Only the low word of the product matters, so the signed and unsigned
  // products agree.
  assign prod_d = a_i * b_i;
  assign acc_d  = prod_tag_q.first ? prod_q : acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q   <= '0;
      prod_tag_q <= '0;
    end else if (en_i) begin
      rd_tag_q   <= tag_i;
      prod_tag_q <= rd_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      if (prod_tag_q.valid) begin
        acc_q <= acc_d;
      end
    end
  end

  always_comb begin
    res_o.valid   = prod_tag_q.valid && prod_tag_q.last_term;
    res_o.value   = acc_d;
    res_o.col     = prod_tag_q.col;
    res_o.row_end = prod_tag_q.row_end;
  end

endmodule

// ===== src/integer_matrix_multiply_unit.sv =====
// Once an A row is complete, each C result passes the RAM read, product and output registers.
// B elements are taken one per cycle while the input is not stalled; a row of A is computed by the
// single multiply-accumulate unit, reading A and B one pair per cycle while the output does not stall.
// The input stalls while a row is computed; output stalls freeze the whole datapath.
// Reset clears the positions, the sequencer and the output valid flag and sets the size to 16;
// the B store and the A row buffer hold undefined data until written.
// ----------------------------------------------------------------------------
// Integer matrix multiply unit
// Loads B into memory, buffers one row of A and emits the matching C row.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic signed [imm_pkg::DATA_W-1:0] element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [imm_pkg::DATA_W-1:0] product_value_o,
  output logic [imm_pkg::COL_W-1:0]         column_index_o,
  output logic                              last_in_row_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imm_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import imm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e            state_d, state_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] n;
  logic [COL_W-1:0]  n_m1;
  logic [NN_W-1:0]   nn;
  logic [B_AW-1:0]   b_pos_d, b_pos_q;
  logic [COL_W-1:0]  a_pos_d, a_pos_q;
  logic [COL_W-1:0]  j_d, j_q;
  logic [COL_W-1:0]  k_d, k_q;
  logic [B_AW-1:0]   b_addr_d, b_addr_q;
  logic              in_xfer, cfg_wr, size_hit, adv, row_done;
  logic [NN_W-1:0]   b_pos_inc;
  mac_tag_t          tag;
  mac_res_t          res;
  logic [DATA_W-1:0] a_rdata, b_rdata;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_last_q;

  assign n    = eff_size(size_q);
  assign n_m1 = COL_W'(n - SIZE_W'(1));
  assign nn   = NN_W'(n) * NN_W'(n);

  // Configuration port.
  assign pready   = 1'b1;
  assign size_hit = (paddr[ADDR_W-1] == REG_MATRIX_SIZE);
  assign cfg_wr   = psel && penable && pwrite && pready && size_hit;
  assign prdata   = size_hit ? 32'(size_q) : '0;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign adv        = !(out_valid_q && out_stall_i);
  assign row_done   = (NN_W'(a_pos_q) + NN_W'(1)) == NN_W'(n);
  assign b_pos_inc  = NN_W'(b_pos_q) + NN_W'(1);

  always_comb begin
    tag.valid     = (state_q == S_RUN);
    tag.first     = (j_q == '0);
    tag.last_term = (j_q == n_m1);
    tag.row_end   = (k_q == n_m1);
    tag.col       = k_q;
  end

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    k_d      = k_q;
    b_addr_d = b_addr_q;
    b_pos_d  = b_pos_q;
    a_pos_d  = a_pos_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && operation_i == OP_STREAM_A) begin
          if (row_done) begin
            a_pos_d  = '0;
            state_d  = S_RUN;
            j_d      = '0;
            k_d      = '0;
            b_addr_d = '0;
          end else begin
            a_pos_d = a_pos_q + COL_W'(1);
          end
        end else if (in_xfer) begin
          b_pos_d = (b_pos_inc >= nn) ? '0 : B_AW'(b_pos_inc);
        end
      end
      S_RUN: begin
        if (adv) begin
          if (tag.last_term) begin
            // Column finished: restart the B walk at the top of the next one.
            j_d      = '0;
            k_d      = k_q + COL_W'(1);
            b_addr_d = B_AW'(k_q) + B_AW'(1);
            if (tag.row_end) begin
              state_d = S_DRAIN;
            end
          end else begin
            j_d      = j_q + COL_W'(1);
            b_addr_d = b_addr_q + B_AW'(n);
          end
        end
      end
      S_DRAIN: begin
        if (adv && res.valid && res.row_end) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_wr) begin
      b_pos_d = '0;
      a_pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= SIZE_W'(MAX_DIM);
      b_pos_q  <= '0;
      a_pos_q  <= '0;
      j_q      <= '0;
      k_q      <= '0;
      b_addr_q <= '0;
    end else begin
      state_q  <= state_d;
      b_pos_q  <= b_pos_d;
      a_pos_q  <= a_pos_d;
      j_q      <= j_d;
      k_q      <= k_d;
      b_addr_q <= b_addr_d;
      if (cfg_wr) begin
        size_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  imm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(B_DEPTH)
  ) u_b_ram (
    .clk_i  (clk_i),
    .we_i   (in_xfer && operation_i == OP_LOAD_B),
    .waddr_i(b_pos_q),
    .wdata_i(element_value_i),
    .re_i   (adv),
    .raddr_i(b_addr_q),
    .rdata_o(b_rdata)
  );

  imm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_DIM)
  ) u_a_ram (
    .clk_i  (clk_i),
    .we_i   (in_xfer && operation_i == OP_STREAM_A),
    .waddr_i(a_pos_q),
    .wdata_i(element_value_i),
    .re_i   (adv),
    .raddr_i(j_q),
    .rdata_o(a_rdata)
  );

  imm_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .tag_i (tag),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .res_o (res)
  );

  // Output register; the datapath only advances when it can take a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_value_q <= res.value;
      out_col_q   <= res.col;
      out_last_q  <= res.row_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_value_q;
  assign column_index_o  = out_col_q;
  assign last_in_row_o   = out_last_q;

endmodule

// ===== src/imm_checker.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply port checker
// Watches the top-level ports for ordering and stall behavior of results.
// ----------------------------------------------------------------------------
module imm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [imm_pkg::DATA_W-1:0] product_value_o,
  input logic [imm_pkg::COL_W-1:0]         column_index_o,
  input logic                              last_in_row_o
);
  import imm_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(product_value_o)
      && $stable(column_index_o) && $stable(last_in_row_o))
    else $error("stalled result changed");

  // Until the last result of a row is shown, the input stays stalled.
  a_row_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_in_row_o |-> in_stall_o)
    else $error("input open while a row is still being produced");

  // Results of a row come out in column order.
  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_in_row_o |=>
      !out_valid_o || column_index_o == $past(column_index_o) + COL_W'(1))
    else $error("result column out of order");

  // The input only stalls after it has taken a transfer.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stalled without a transfer");

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .product_value_o(product_value_o),
  .column_index_o (column_index_o),
  .last_in_row_o  (last_in_row_o)
);

// ===== tb/sv/tb_integer_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply unit testbench
// Loads B, streams rows of A and checks every C element against a shadow
// model of the unit. The random traffic runs under varied sender idling and
// receiver stalls, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_integer_matrix_multiply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import imm_pkg::*;

  localparam int SETTLE_CYCLES = MAX_DIM * MAX_DIM + 2 * MAX_DIM;
  localparam int STALL_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [ADDR_W-1:0] SIZE_ADDR = ADDR_W'(4 * int'(REG_MATRIX_SIZE));

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [COL_W-1:0]  col;
    logic              last;
  } c_elem_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     operation_i;
  logic signed [DATA_W-1:0] element_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] product_value_o;
  logic [COL_W-1:0]         column_index_o;
  logic                     last_in_row_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  // Shadow copy of the unit state.
  logic [DATA_W-1:0] b_image [B_DEPTH];
  logic [DATA_W-1:0] a_row_image [MAX_DIM];
  int                b_fill_pos = 0;
  int                a_fill_pos = 0;
  logic [SIZE_W-1:0] size_code = SIZE_W'(MAX_DIM);

  c_elem_t c_row_q[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_out_cycles = 0;

  integer_matrix_multiply_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .product_value_o (product_value_o),
    .column_index_o  (column_index_o),
    .last_in_row_o   (last_in_row_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  function automatic int dim_in_use();
    int n;
    if (size_code == '0) begin
      n = 1;
    end else if (size_code > SIZE_W'(MAX_DIM)) begin
      n = MAX_DIM;
    end else begin
      n = int'(size_code);
    end
    return n;
  endfunction

  // Advances the shadow state by one accepted element and queues the C row
  // that it completes, if any.
  task automatic predict_c_row(input logic op, input logic [DATA_W-1:0] val);
    int                n;
    logic [DATA_W-1:0] acc;
    c_elem_t           elem;
    n = dim_in_use();
    if (op == OP_LOAD_B) begin
      if (b_fill_pos >= n * n) b_fill_pos = 0;
      b_image[b_fill_pos] = val;
      b_fill_pos++;
      if (b_fill_pos >= n * n) b_fill_pos = 0;
    end else begin
      if (a_fill_pos >= n) a_fill_pos = 0;
      a_row_image[a_fill_pos] = val;
      a_fill_pos++;
      if (a_fill_pos == n) begin
        a_fill_pos = 0;
        for (int k = 0; k < n; k++) begin
          acc = '0;
          for (int j = 0; j < n; j++) begin
            acc = acc + DATA_W'(a_row_image[j] * b_image[j * n + k]);
          end
          elem.value = acc;
          elem.col   = COL_W'(k);
          elem.last  = (k == n - 1);
          c_row_q.push_back(elem);
        end
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_element();
    logic [DATA_W-1:0] v;
    case ($urandom_range(7))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'hFFFF_FFFF;
      3: v = DATA_W'($urandom_range(15));
      4: v = -DATA_W'($urandom_range(15));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_element(input logic op, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    element_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_c_row(op, val);
  endtask

  // Waits until every queued C element has left and the datapath has settled.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (c_row_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_matrix_size(input logic [SIZE_W-1:0] code);
    drain_block();
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SIZE_ADDR;
    pwdata  <= 32'(code);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_code  = code;
    b_fill_pos = 0;
    a_fill_pos = 0;
    // Read the register straight back; psel stays high between the two.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(code)) begin
      note_error($sformatf("matrix_size readback: expected %h, got %h", 32'(code), prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    write_matrix_size(SIZE_W'(2));
    send_element(OP_LOAD_B, 32'h8000_0000);
    send_element(OP_LOAD_B, 32'h7FFF_FFFF);
    send_element(OP_LOAD_B, 32'hFFFF_FFFF);
    send_element(OP_LOAD_B, 32'h0000_0001);
    send_element(OP_STREAM_A, 32'h7FFF_FFFF);
    send_element(OP_STREAM_A, 32'h8000_0000);
    send_element(OP_STREAM_A, 32'hFFFF_FFFF);
    send_element(OP_STREAM_A, 32'h0000_0000);
    // A B element arriving mid-row overwrites the first entry before the
    // row completes, so the row must use the new value.
    send_element(OP_STREAM_A, 32'h0000_0001);
    send_element(OP_LOAD_B, 32'h0000_0005);
    send_element(OP_STREAM_A, 32'h0000_0003);
    // The third of these wraps the load position, so the fourth lands on
    // the first entry again.
    send_element(OP_LOAD_B, 32'h0000_0006);
    send_element(OP_LOAD_B, 32'h0000_0007);
    send_element(OP_LOAD_B, 32'h0000_0008);
    send_element(OP_LOAD_B, 32'hFFFF_FFFE);
    send_element(OP_STREAM_A, 32'h0000_0002);
    send_element(OP_STREAM_A, 32'hFFFF_FFFD);
  endtask

  // A size of zero behaves as a 1x1 product.
  task automatic test_size_zero_as_one();
    write_matrix_size('0);
    send_element(OP_LOAD_B, 32'hFFFF_FFF9);
    send_element(OP_STREAM_A, 32'hFFFF_FFFF);
    send_element(OP_STREAM_A, 32'h8000_0000);
    send_element(OP_STREAM_A, 32'h0000_0005);
    send_element(OP_LOAD_B, 32'h7FFF_FFFF);
    send_element(OP_LOAD_B, 32'h0000_0003);
    send_element(OP_STREAM_A, 32'hFFFF_FFFE);
  endtask

  task automatic test_random_traffic(input logic [SIZE_W-1:0] code, input int n_items);
    int n;
    write_matrix_size(code);
    n = dim_in_use();
    for (int i = 0; i < n * n; i++) begin
      send_element(OP_LOAD_B, pick_element());
    end
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 15) begin
        send_element(OP_LOAD_B, pick_element());
      end else begin
        send_element(OP_STREAM_A, pick_element());
      end
    end
  endtask

  // Codes above the maximum act as the maximum; one row at the full size,
  // with a B element landing mid-row.
  task automatic test_full_dimension();
    write_matrix_size('1);
    for (int i = 0; i < B_DEPTH; i++) begin
      send_element(OP_LOAD_B, pick_element());
    end
    for (int i = 0; i < MAX_DIM; i++) begin
      if (i == 5) begin
        send_element(OP_LOAD_B, pick_element());
      end
      send_element(OP_STREAM_A, pick_element());
    end
  endtask

  // The receiver holds off long enough for the unit to back up its input.
  task automatic test_output_hold_off();
    write_matrix_size(SIZE_W'(2));
    for (int i = 0; i < 4; i++) begin
      send_element(OP_LOAD_B, pick_element());
    end
    hold_out_cycles = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_element(OP_STREAM_A, pick_element());
    end
  endtask

  always @(posedge clk_i) begin : c_row_monitor
    c_elem_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (c_row_q.size() == 0) begin
        note_error($sformatf("unexpected product %h col %0d last %0b",
                             product_value_o, column_index_o, last_in_row_o));
      end else begin
        want = c_row_q.pop_front();
        if (product_value_o !== want.value || column_index_o !== want.col ||
            last_in_row_o !== want.last) begin
          note_error($sformatf(
            "product mismatch: expected %h col %0d last %0b, got %h col %0d last %0b",
            want.value, want.col, want.last,
            product_value_o, column_index_o, last_in_row_o));
        end
      end
    end
    if (hold_out_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_out_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    operation_i     <= OP_LOAD_B;
    element_value_i <= '0;
    out_stall_i     <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 12;
    recv_stall_pct = 71;
    test_directed_extremes();
    test_size_zero_as_one();
    test_random_traffic(SIZE_W'(3), 16);

    send_idle_pct  = 71;
    recv_stall_pct = 12;
    test_full_dimension();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_hold_off();

    drain_block();
    if (error_count == 0 && c_row_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/imm_pkg.sv
src/imm_ram.sv
src/imm_mac.sv
src/integer_matrix_multiply_unit.sv
src/imm_checker.sv
tb/sv/tb_integer_matrix_multiply_unit.sv
